### rtl/core/lztsd_pkg.sv
// Shared types and codes for the LZ token stream decoder.
// No dependencies.
package lztsd_pkg;

  // Parse phases of the token decoder
  localparam logic [2:0] PH_CTRL     = 3'd0;
  localparam logic [2:0] PH_LITCOUNT = 3'd1;
  localparam logic [2:0] PH_LENGTH   = 3'd2;
  localparam logic [2:0] PH_LITERALS = 3'd3;
  localparam logic [2:0] PH_OFFLO    = 3'd4;
  localparam logic [2:0] PH_OFFHI    = 3'd5;

  // Error codes on the result channel
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TRUNC   = 2'd1;
  localparam logic [1:0] ERR_DIST    = 2'd2;
  localparam logic [1:0] ERR_OVERRUN = 2'd3;

  // What one input item leads to
  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_ONE       = 2'd1,
    ACT_LIT_TRUNC = 2'd2,
    ACT_COPY      = 2'd3
  } act_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic push1;
    logic push2;
    logic rd;
    logic wr;
    logic chunk;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic out_free;
    logic chunk_end;
    logic left_zero;
  } sts_t;

endpackage

### rtl/core/lztsd_in_if.sv
// Input channel: one compressed byte per item.
// No dependencies.
interface lztsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       final_byte;
  modport source (output valid, code_byte, final_byte, input ready);
  modport sink   (input valid, code_byte, final_byte, output ready);
endinterface

### rtl/core/lztsd_out_if.sv
// Result channel: one chunk of decoded bytes per item.
// No dependencies.
interface lztsd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        chunk_last;
  logic        stream_end;
  logic [1:0]  error_code;
  logic [31:0] produced_total;
  modport source (output valid, out_bytes, byte_count, chunk_last, stream_end, error_code,
                  produced_total, input ready);
  modport sink   (input valid, out_bytes, byte_count, chunk_last, stream_end, error_code,
                  produced_total, output ready);
endinterface

### rtl/core/lztsd_cfg_if.sv
// Configuration write channel for the output limit register.
// No dependencies.
interface lztsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/core/lztsd_ctrl.sv
// Sequencer for the decoder: accept, execute, result pushes and copy loop.
// Depends on lztsd_pkg.
module lztsd_ctrl
  import lztsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RES1  = 3'd2;
  localparam logic [2:0] S_RES2  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_CHUNK = 3'd6;

  logic [2:0] state_q, state_d;
  logic       two_q, two_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    two_d   = two_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        two_d      = (sts_i.act == ACT_LIT_TRUNC);
        unique case (sts_i.act)
          ACT_NONE:      state_d = S_IDLE;
          ACT_ONE:       state_d = S_RES1;
          ACT_LIT_TRUNC: state_d = S_RES1;
          ACT_COPY:      state_d = S_RD;
          default:       state_d = S_IDLE;
        endcase
      end
      S_RES1: begin
        if (sts_i.out_free) begin
          cmd_o.push1 = 1'b1;
          state_d     = two_q ? S_RES2 : S_IDLE;
        end
      end
      S_RES2: begin
        if (sts_i.out_free) begin
          cmd_o.push2 = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_WR;
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = sts_i.chunk_end ? S_CHUNK : S_RD;
      end
      S_CHUNK: begin
        if (sts_i.out_free) begin
          cmd_o.chunk = 1'b1;
          state_d     = sts_i.left_zero ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      two_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      two_q   <= two_d;
    end
  end

endmodule

### rtl/core/lztsd_dp.sv
// Datapath: token parse registers, history memory, chunk lanes, result register.
// Depends on lztsd_pkg.
module lztsd_dp
  import lztsd_pkg::*;
#(
  parameter int WINDOW_BYTES = 65536,
  parameter int LANE_BYTES   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  code_byte_i,
  input  logic        final_byte_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [63:0] out_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        chunk_last_o,
  output logic        stream_end_o,
  output logic [1:0]  error_code_o,
  output logic [31:0] produced_total_o
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int KW = $clog2(LANE_BYTES + 1);
  localparam int IW = (LANE_BYTES > 1) ? $clog2(LANE_BYTES) : 1;
  localparam logic [16:0] WIN17  = 17'(WINDOW_BYTES);
  localparam logic [AW-1:0] WLAST = AW'(WINDOW_BYTES - 1);
  localparam logic [KW-1:0] LANEK = KW'(LANE_BYTES);

  // Configuration and stream state
  logic [31:0]   limit_q;
  logic [2:0]    phase_q;
  logic [7:0]    lit_q;
  logic [8:0]    ml_q;
  logic [7:0]    dh_q, dl_q;
  logic [AW-1:0] wp_q;
  logic [31:0]   prod_q;
  logic          disc_q;

  // Latched item and copy state
  logic [7:0]    byte_q;
  logic          fin_q;
  logic [8:0]    left_q;
  logic [15:0]   dist_q;
  logic [7:0]    rdata_q;
  logic [7:0]    lane_q [LANE_BYTES];
  logic [KW-1:0] k_q;

  // Pending single result
  logic [7:0]  pb_q;
  logic        pc_q;
  logic [1:0]  pe_q;
  logic        pend_q;
  logic [31:0] pt_q;

  // Output register
  logic        ov_q;
  logic [63:0] ob_q;
  logic [3:0]  oc_q;
  logic        ol_q, oe_q;
  logic [1:0]  oerr_q;
  logic [31:0] ot_q;

  logic [7:0] mem [WINDOW_BYTES];

  // Decode of the latched byte
  logic [2:0]  ph_n;
  logic [7:0]  lit_n, dh_n, dl_n;
  logic [8:0]  ml_n;
  logic [1:0]  err_n;
  logic        lit_go, copy_go;
  logic [15:0] dist_n;
  act_e        act;

  always_comb begin
    ph_n    = phase_q;
    lit_n   = lit_q;
    ml_n    = ml_q;
    dh_n    = dh_q;
    dl_n    = dl_q;
    err_n   = ERR_NONE;
    lit_go  = 1'b0;
    copy_go = 1'b0;
    dist_n  = 16'd0;
    unique case (phase_q)
      PH_CTRL: begin
        dh_n  = {6'd0, byte_q[3:2]};
        lit_n = (byte_q[1:0] != 2'd0) ? {6'd0, byte_q[1:0] - 2'd1} : 8'd0;
        ml_n  = (byte_q[7:4] != 4'd0) ? 9'({5'd0, byte_q[7:4]} + 9'd2) : 9'd0;
        if (byte_q[1:0] == 2'd0) ph_n = PH_LITCOUNT;
        else if (byte_q[7:4] == 4'd0) ph_n = PH_LENGTH;
        else ph_n = (lit_n != 8'd0) ? PH_LITERALS : ((ml_n != 9'd0) ? PH_OFFLO : PH_CTRL);
      end
      PH_LITCOUNT: begin
        lit_n = (byte_q != 8'd0) ? byte_q - 8'd1 : 8'd0;
        if (ml_q == 9'd0) ph_n = PH_LENGTH;
        else ph_n = (lit_n != 8'd0) ? PH_LITERALS : PH_OFFLO;
      end
      PH_LENGTH: begin
        ml_n = (byte_q != 8'd0) ? {1'b0, byte_q} + 9'd2 : 9'd0;
        ph_n = (lit_q != 8'd0) ? PH_LITERALS : ((ml_n != 9'd0) ? PH_OFFLO : PH_CTRL);
      end
      PH_LITERALS: begin
        if (prod_q >= limit_q) begin
          err_n = ERR_OVERRUN;
        end else begin
          lit_go = 1'b1;
          lit_n  = lit_q - 8'd1;
          ph_n   = (lit_n != 8'd0) ? PH_LITERALS : ((ml_q != 9'd0) ? PH_OFFLO : PH_CTRL);
        end
      end
      PH_OFFLO, PH_OFFHI: begin
        if (phase_q == PH_OFFLO) dl_n = byte_q;
        else dh_n = byte_q;
        if (phase_q == PH_OFFLO && dh_q == 8'd3) begin
          ph_n = PH_OFFHI;
        end else begin
          dist_n = {dh_n, dl_n};
          ph_n   = PH_CTRL;
          ml_n   = 9'd0;
          dh_n   = 8'd0;
          dl_n   = 8'd0;
          if (dist_n == 16'd0 || {16'd0, dist_n} > prod_q || {1'b0, dist_n} > WIN17)
            err_n = ERR_DIST;
          else if (33'(prod_q) + 33'(ml_q) > 33'(limit_q))
            err_n = ERR_OVERRUN;
          else
            copy_go = 1'b1;
        end
      end
      default: ph_n = PH_CTRL;
    endcase
    if (err_n == ERR_NONE && fin_q && ph_n != PH_CTRL) err_n = ERR_TRUNC;

    if (disc_q) act = ACT_NONE;
    else if (err_n != ERR_NONE) act = lit_go ? ACT_LIT_TRUNC : ACT_ONE;
    else if (copy_go) act = ACT_COPY;
    else if (lit_go || fin_q) act = ACT_ONE;
    else act = ACT_NONE;
  end

  logic out_free;
  assign out_free = !ov_q || out_ready_i;

  assign sts_o.act       = act;
  assign sts_o.out_free  = out_free;
  assign sts_o.chunk_end = (k_q + KW'(1) == LANEK) || (left_q == 9'd1);
  assign sts_o.left_zero = (left_q == 9'd0);

  // History read address, modulo the window
  logic [16:0]   wp17, d17, ra17;
  logic [AW-1:0] wp_inc;
  assign wp17   = 17'(wp_q);
  assign d17    = {1'b0, dist_q};
  assign ra17   = (wp17 >= d17) ? wp17 - d17 : wp17 + WIN17 - d17;
  assign wp_inc = (wp_q == WLAST) ? '0 : wp_q + AW'(1);

  logic          mem_we;
  logic [7:0]    mem_wd;
  assign mem_we = (cmd_i.exec && act != ACT_NONE && lit_go) || cmd_i.wr;
  assign mem_wd = cmd_i.wr ? rdata_q : byte_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wp_q] <= mem_wd;
    if (cmd_i.rd) rdata_q <= mem[ra17[AW-1:0]];
  end

  logic [63:0] word;
  always_comb begin
    word = '0;
    for (int i = 0; i < LANE_BYTES; i++) word[8*i +: 8] = lane_q[i];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= code_byte_i;
      fin_q  <= final_byte_i;
    end
    if (cmd_i.exec) begin
      pb_q   <= lit_go ? byte_q : 8'd0;
      pc_q   <= lit_go;
      pe_q   <= (act == ACT_LIT_TRUNC) ? ERR_NONE : err_n;
      pend_q <= (act == ACT_LIT_TRUNC) ? 1'b0 : (fin_q || err_n != ERR_NONE);
      pt_q   <= prod_q + {31'd0, lit_go};
      left_q <= ml_q;
      dist_q <= dist_n;
      for (int i = 0; i < LANE_BYTES; i++) lane_q[i] <= 8'd0;
    end
    if (cmd_i.wr) begin
      lane_q[k_q[IW-1:0]] <= rdata_q;
      left_q <= left_q - 9'd1;
    end
    if (cmd_i.chunk) begin
      for (int i = 0; i < LANE_BYTES; i++) lane_q[i] <= 8'd0;
    end
    if (cmd_i.push1) begin
      ob_q   <= {56'd0, pb_q};
      oc_q   <= {3'd0, pc_q};
      // only a literal followed by a truncation error is not the last result
      ol_q   <= pend_q || !fin_q;
      oe_q   <= pend_q;
      oerr_q <= pe_q;
      ot_q   <= pt_q;
    end else if (cmd_i.push2) begin
      ob_q   <= '0;
      oc_q   <= 4'd0;
      ol_q   <= 1'b1;
      oe_q   <= 1'b1;
      oerr_q <= ERR_TRUNC;
      ot_q   <= pt_q;
    end else if (cmd_i.chunk) begin
      ob_q   <= word;
      oc_q   <= 4'(k_q);
      ol_q   <= (left_q == 9'd0);
      oe_q   <= (left_q == 9'd0) && fin_q;
      oerr_q <= ERR_NONE;
      ot_q   <= prod_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 32'hFFFF_FFFF;
      phase_q <= PH_CTRL;
      lit_q   <= '0;
      ml_q    <= '0;
      dh_q    <= '0;
      dl_q    <= '0;
      wp_q    <= '0;
      prod_q  <= '0;
      disc_q  <= 1'b0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      if (cmd_i.exec) begin
        k_q <= '0;
        if (disc_q) begin
          if (fin_q) disc_q <= 1'b0;
        end else if (err_n != ERR_NONE || (fin_q && !copy_go)) begin
          phase_q <= PH_CTRL;
          lit_q   <= '0;
          ml_q    <= '0;
          dh_q    <= '0;
          dl_q    <= '0;
          wp_q    <= '0;
          prod_q  <= '0;
          disc_q  <= (err_n != ERR_NONE) && !fin_q;
        end else begin
          phase_q <= ph_n;
          lit_q   <= lit_n;
          ml_q    <= ml_n;
          dh_q    <= dh_n;
          dl_q    <= dl_n;
          if (lit_go) begin
            wp_q   <= wp_inc;
            prod_q <= prod_q + 32'd1;
          end
        end
      end
      if (cmd_i.wr) begin
        wp_q   <= wp_inc;
        prod_q <= prod_q + 32'd1;
        k_q    <= k_q + KW'(1);
      end
      if (cmd_i.chunk) begin
        k_q <= '0;
        if (left_q == 9'd0 && fin_q) begin
          wp_q   <= '0;
          prod_q <= '0;
        end
      end
      if (cmd_i.push1 || cmd_i.push2 || cmd_i.chunk) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o      = ov_q;
  assign out_bytes_o      = ob_q;
  assign byte_count_o     = oc_q;
  assign chunk_last_o     = ol_q;
  assign stream_end_o     = oe_q;
  assign error_code_o     = oerr_q;
  assign produced_total_o = ot_q;

endmodule

### rtl/core/lz_token_stream_decoder_unit.sv
// LZ token stream decoder: one compressed byte per item in, byte chunks out.
// A header byte is accepted, then executed; a literal also pushes a result; a match then
// reads and writes back each copied byte through the single history port, pushing each chunk.
// Input is taken only between items; a result push that waits for a free output stalls input.
// Reset clears parse state, counts and the output valid flag; the limit returns to all ones.
// The history memory is not cleared; distance checks keep reads within written bytes.
module lz_token_stream_decoder_unit
  import lztsd_pkg::*;
#(
  parameter int WINDOW_BYTES = 65536,
  parameter int LANE_BYTES   = 8
) (
  input logic          clk_i,
  input logic          rst_ni,
  lztsd_in_if.sink     in_i,
  lztsd_out_if.source  out_o,
  lztsd_cfg_if.sink    cfg_i
);

  cmd_t cmd;
  sts_t sts;

  // limit register always takes a write
  assign cfg_i.ready = 1'b1;

  lztsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lztsd_dp #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .LANE_BYTES   (LANE_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .code_byte_i      (in_i.code_byte),
    .final_byte_i     (in_i.final_byte),
    .cfg_we_i         (cfg_i.valid),
    .cfg_data_i       (cfg_i.data),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_bytes_o      (out_o.out_bytes),
    .byte_count_o     (out_o.byte_count),
    .chunk_last_o     (out_o.chunk_last),
    .stream_end_o     (out_o.stream_end),
    .error_code_o     (out_o.error_code),
    .produced_total_o (out_o.produced_total)
  );

endmodule
